>>> design/sensor_frame_check_convert_assert.svh
// Assertion macros for the sensor frame checker and converter.
`ifndef SENSOR_FRAME_CHECK_CONVERT_ASSERT_SVH
`define SENSOR_FRAME_CHECK_CONVERT_ASSERT_SVH

// Same-cycle implication.
`define SFCC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SFCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sfcc_pkg.sv
// Constants, types and the CRC function of the sensor frame checker and converter.
package sfcc_pkg;

   localparam logic [7:0]   CRC_POLY        = 8'h31;
   localparam logic [15:0]  RAW_MASK        = 16'hFFFC;
   localparam int           KIND_BIT        = 1;

   localparam logic [14:0]  TEMP_GAIN       = 15'd17572;
   localparam logic [15:0]  TEMP_OFFSET     = 16'd4685;
   localparam logic [14:0]  HUM_GAIN        = 15'd12500;
   localparam logic [15:0]  HUM_OFFSET      = 16'd600;

   // floor(x / 100) == (x * 5243) >> 19 for x below 43690
   localparam logic [12:0]  DIV100_RECIP    = 13'd5243;
   localparam int           DIV100_SHIFT    = 19;
   localparam logic [6:0]   CENTI_PER_WHOLE = 7'd100;
   localparam logic [13:0]  MICRO_PER_CENTI = 14'd10000;

   typedef logic [1:0] pos_type;
   localparam pos_type POS_HIGH  = 2'd0;
   localparam pos_type POS_LOW   = 2'd1;
   localparam pos_type POS_CHECK = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_CRC  = 2'd1;
   localparam status_type STATUS_KIND = 2'd2;

   typedef struct packed {
      status_type   status;
      logic [15:0]  raw;
      logic [7:0]   crc;
      logic [14:0]  centi;
      logic         neg;
      logic [13:0]  mag;
      logic [7:0]   quot;
   } check_stage_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> design/sensor_frame_check_convert.sv
// Sensor frame checker and converter: CRC-8 check and unit conversion of 3-byte frames.
//
// Takes one frame byte per cycle (raw high, raw low, checksum); req_frame_start marks a
// first byte and drops any partial frame. The conversion product is formed when the low
// byte arrives; on the checksum byte the status and the divide-by-100 reciprocal product
// are registered in a check stage, which hands the result to the output register once
// that register is free. Input is stalled only while both the check stage and the output
// register hold results and rsp_stall is high, so one byte a cycle is sustained otherwise.
// Non-ok results carry zero centi, whole and micro values.
module sensor_frame_check_convert (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         req_func,
   input  logic         req_frame_start,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [15:0]  rsp_raw_value,
   output logic signed [14:0] rsp_centi_value,
   output logic signed [8:0]  rsp_whole_part,
   output logic signed [20:0] rsp_micro_part,
   output logic [7:0]   rsp_computed_crc
);
   import sfcc_pkg::*;

   `include "sensor_frame_check_convert_assert.svh"

   pos_type          count_ff, count_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       low_ff, low_in;
   logic [7:0]       crc_ff, crc_in;
   logic             kind_ff, kind_in;
   logic [14:0]      centi_ff, centi_in;

   logic             s1_valid_ff, s1_valid_in;
   check_stage_type  s1_ff, s1_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [15:0]      rsp_raw_ff;
   logic [14:0]      rsp_centi_ff;
   logic [8:0]       rsp_whole_ff, rsp_whole_in;
   logic [20:0]      rsp_micro_ff, rsp_micro_in;
   logic [7:0]       rsp_crc_ff;

   logic             accept, out_free;
   logic             is_low, is_check, is_high;
   logic [15:0]      conv_raw;
   logic [14:0]      conv_gain;
   logic [30:0]      conv_prod;
   logic [15:0]      conv_centi;
   status_type       chk_status;
   logic [14:0]      chk_centi, chk_negated;
   logic [26:0]      quot_prod;
   logic [14:0]      quot_times100;
   logic [13:0]      rem_wide;
   logic [19:0]      micro_mag;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign is_low   = !req_frame_start && (count_ff == POS_LOW);
   assign is_check = !req_frame_start && (count_ff == POS_CHECK);
   assign is_high  = !is_low && !is_check;

   // conversion on the low byte
   always_comb begin
      conv_raw   = {high_ff, req_rx_byte} & RAW_MASK;
      conv_gain  = kind_ff ? HUM_GAIN : TEMP_GAIN;
      conv_prod  = 31'(conv_gain) * 31'(conv_raw);
      conv_centi = {1'b0, conv_prod[30:16]} - (kind_ff ? HUM_OFFSET : TEMP_OFFSET);
   end

   // frame state
   always_comb begin
      count_in = count_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      crc_in   = crc_ff;
      kind_in  = kind_ff;
      centi_in = centi_ff;
      if (accept) begin
         priority if (is_low) begin
            low_in   = req_rx_byte;
            crc_in   = crc8_update(crc_ff, req_rx_byte);
            centi_in = conv_centi[14:0];
            count_in = POS_CHECK;
         end else if (is_check) begin
            count_in = POS_HIGH;
         end else begin
            high_in  = req_rx_byte;
            kind_in  = req_func;
            crc_in   = crc8_update(8'h00, req_rx_byte);
            count_in = POS_LOW;
         end
      end
   end

   // checksum byte: status and quotient
   always_comb begin
      priority if (crc_ff != req_rx_byte) begin
         chk_status = STATUS_CRC;
      end else if (low_ff[KIND_BIT] != kind_ff) begin
         chk_status = STATUS_KIND;
      end else begin
         chk_status = STATUS_OK;
      end
      chk_centi   = (chk_status == STATUS_OK) ? centi_ff : 15'd0;
      chk_negated = 15'd0 - chk_centi;
      s1_in.status = chk_status;
      s1_in.raw    = {high_ff, low_ff} & RAW_MASK;
      s1_in.crc    = crc_ff;
      s1_in.centi  = chk_centi;
      s1_in.neg    = chk_centi[14];
      s1_in.mag    = chk_centi[14] ? chk_negated[13:0] : chk_centi[13:0];
      quot_prod    = 27'(s1_in.mag) * 27'(DIV100_RECIP);
      s1_in.quot   = quot_prod[DIV100_SHIFT +: 8];
   end

   assign s1_valid_in  = (accept && is_check) || (s1_valid_ff && !out_free);
   assign rsp_valid_in = (s1_valid_ff && out_free) || (rsp_valid_ff && !out_free);

   // remainder and signed split
   always_comb begin
      quot_times100 = 15'(s1_ff.quot) * 15'(CENTI_PER_WHOLE);
      rem_wide      = s1_ff.mag - quot_times100[13:0];
      micro_mag     = 20'(rem_wide[6:0]) * 20'(MICRO_PER_CENTI);
      rsp_whole_in  = s1_ff.neg ? (9'd0 - {1'b0, s1_ff.quot}) : {1'b0, s1_ff.quot};
      rsp_micro_in  = s1_ff.neg ? (21'd0 - {1'b0, micro_mag}) : {1'b0, micro_mag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= POS_HIGH;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff  <= high_in;
      low_ff   <= low_in;
      crc_ff   <= crc_in;
      kind_ff  <= kind_in;
      centi_ff <= centi_in;
      if (accept && is_check) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && out_free) begin
         rsp_status_ff <= s1_ff.status;
         rsp_raw_ff    <= s1_ff.raw;
         rsp_centi_ff  <= s1_ff.centi;
         rsp_whole_ff  <= rsp_whole_in;
         rsp_micro_ff  <= rsp_micro_in;
         rsp_crc_ff    <= s1_ff.crc;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_raw_value    = rsp_raw_ff;
   assign rsp_centi_value  = $signed(rsp_centi_ff);
   assign rsp_whole_part   = $signed(rsp_whole_ff);
   assign rsp_micro_part   = $signed(rsp_micro_ff);
   assign rsp_computed_crc = rsp_crc_ff;

   `SFCC_ASSERT_SAME(a_err_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff != STATUS_OK),
      (rsp_centi_ff == 15'd0) && (rsp_whole_ff == 9'd0) && (rsp_micro_ff == 21'd0),
      "error item carries nonzero value")
   `SFCC_ASSERT_SAME(a_split_sum, clock, reset,
      rsp_valid_ff,
      (int'(rsp_centi_value) * 10000) ==
         (int'(rsp_whole_part) * 1000000 + int'(rsp_micro_part)),
      "whole and micro parts do not recombine to centi value")
   `SFCC_ASSERT_NEXT(a_check_loads, clock, reset,
      accept && is_check,
      s1_valid_ff,
      "checksum item did not reach check stage")
   `SFCC_ASSERT_NEXT(a_first_byte, clock, reset,
      accept && is_high,
      count_ff == POS_LOW,
      "first byte did not advance frame position")

endmodule

>>> sim/sfcc_tb_pkg.sv
// Testbench package: CRC-8 (poly 0x31) helpers for frame stimulus and prediction.
`timescale 1ns / 100ps

package sfcc_tb_pkg;

   localparam logic [7:0] FRAME_CRC_POLY = 8'h31;

   // MSB-first, one data bit per step
   function automatic logic [7:0] crc31_next(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ data[i];
         c = {c[6:0], 1'b0} ^ (fb ? FRAME_CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_checksum(input logic [15:0] value);
      return crc31_next(crc31_next(8'h00, value[15:8]), value[7:0]);
   endfunction

endpackage

>>> sim/sfcc_checker.sv
// Frame checker: tracks frame bytes, predicts status and converted values, compares results.
`timescale 1ns / 100ps

module sfcc_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_func,
   input  logic               req_frame_start,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic [15:0]        rsp_raw_value,
   input  logic signed [14:0] rsp_centi_value,
   input  logic signed [8:0]  rsp_whole_part,
   input  logic signed [20:0] rsp_micro_part,
   input  logic [7:0]         rsp_computed_crc,
   output int                 fail_count,
   output int                 pending_results,
   output int                 bytes_seen,
   output int                 frames_ok,
   output int                 frames_crc_err,
   output int                 frames_kind_err
);
   import sfcc_pkg::*;
   import sfcc_tb_pkg::*;

   localparam logic [15:0] VALUE_MASK      = 16'hFFFC;
   localparam int unsigned TEMP_SCALE      = 17572;
   localparam int unsigned HUM_SCALE       = 12500;
   localparam int          TEMP_BIAS       = 4685;
   localparam int          HUM_BIAS        = 600;
   localparam int          CENTI_PER_UNIT  = 100;
   localparam int          MICRO_PER_CENTI = 10000;
   localparam int          MAX_PRINTED     = 50;

   typedef struct {
      status_type         status;
      logic [15:0]        raw;
      logic signed [14:0] centi;
      logic signed [8:0]  whole;
      logic signed [20:0] micro;
      logic [7:0]         crc;
   } frame_result_type;

   frame_result_type expected_q[$];

   pos_type    frame_pos;
   logic [7:0] value_hi;
   logic [7:0] value_lo;
   logic [7:0] crc_acc;
   logic       kind_expected;

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_PRINTED) begin
         $display("%0t ERROR: %s", $time, msg);
      end
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got,
                              input logic signed [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   task automatic take_byte(input logic [7:0] b, input logic fn, input logic fs);
      frame_result_type r;
      logic [15:0]      raw;
      int unsigned      prod;
      int               centi;
      int               whole;
      int               micro;
      if (fs || frame_pos > POS_CHECK) begin
         frame_pos = POS_HIGH;
      end
      case (frame_pos)
         POS_HIGH: begin
            value_hi      = b;
            kind_expected = fn;
            crc_acc       = crc31_next(8'h00, b);
            frame_pos     = POS_LOW;
         end
         POS_LOW: begin
            value_lo  = b;
            crc_acc   = crc31_next(crc_acc, b);
            frame_pos = POS_CHECK;
         end
         default: begin
            frame_pos = POS_HIGH;
            raw = {value_hi, value_lo} & VALUE_MASK;
            centi = 0;
            if (crc_acc != b) begin
               r.status = STATUS_CRC;
               frames_crc_err++;
            end else if (value_lo[1] != kind_expected) begin
               r.status = STATUS_KIND;
               frames_kind_err++;
            end else begin
               r.status = STATUS_OK;
               frames_ok++;
               if (kind_expected) begin
                  prod  = HUM_SCALE * raw;
                  centi = int'(prod >> 16) - HUM_BIAS;
               end else begin
                  prod  = TEMP_SCALE * raw;
                  centi = int'(prod >> 16) - TEMP_BIAS;
               end
            end
            whole   = centi / CENTI_PER_UNIT;
            micro   = (centi % CENTI_PER_UNIT) * MICRO_PER_CENTI;
            r.raw   = raw;
            r.crc   = crc_acc;
            r.centi = centi[14:0];
            r.whole = whole[8:0];
            r.micro = micro[20:0];
            expected_q.push_back(r);
         end
      endcase
   endtask

   always @(posedge clock) begin
      frame_result_type e;
      if (reset) begin
         frame_pos     = POS_HIGH;
         value_hi      = 8'h00;
         value_lo      = 8'h00;
         crc_acc       = 8'h00;
         kind_expected = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            bytes_seen++;
            take_byte(req_rx_byte, req_func, req_frame_start);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with no frame pending");
            end else begin
               e = expected_q.pop_front();
               check_field("status", rsp_status, e.status);
               check_field("raw_value", rsp_raw_value, e.raw);
               check_field("centi_value", rsp_centi_value, e.centi);
               check_field("whole_part", rsp_whole_part, e.whole);
               check_field("micro_part", rsp_micro_part, e.micro);
               check_field("computed_crc", rsp_computed_crc, e.crc);
            end
         end
      end
      pending_results = expected_q.size();
   end

endmodule

>>> sim/tb_top.sv
// Testbench top: clock, reset, frame byte stimulus, result stall pattern and verdict.
`timescale 1ns / 100ps

module tb_top;
   import sfcc_tb_pkg::*;

   localparam int RANDOM_BYTES = 2000;
   localparam int END_WAIT     = 20;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_func = 1'b0;
   logic               req_frame_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_raw_value;
   logic signed [14:0] rsp_centi_value;
   logic signed [8:0]  rsp_whole_part;
   logic signed [20:0] rsp_micro_part;
   logic [7:0]         rsp_computed_crc;

   int fail_count;
   int pending_results;
   int bytes_seen;
   int frames_ok;
   int frames_crc_err;
   int frames_kind_err;

   int             bytes_sent = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_hold = 0;

   sensor_frame_check_convert DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_func         (req_func),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_centi_value  (rsp_centi_value),
      .rsp_whole_part   (rsp_whole_part),
      .rsp_micro_part   (rsp_micro_part),
      .rsp_computed_crc (rsp_computed_crc)
   );

   sfcc_checker frame_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_func         (req_func),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_centi_value  (rsp_centi_value),
      .rsp_whole_part   (rsp_whole_part),
      .rsp_micro_part   (rsp_micro_part),
      .rsp_computed_crc (rsp_computed_crc),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .bytes_seen       (bytes_seen),
      .frames_ok        (frames_ok),
      .frames_crc_err   (frames_crc_err),
      .frames_kind_err  (frames_kind_err)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // result side back-pressure, in modes chosen at random and held for a random span
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_hold = $urandom_range(8, 60);
      end else begin
         stall_hold--;
      end
      case (stall_mode)
         STALL_NONE:      rsp_stall <= 1'b0;
         STALL_LIGHT:     rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:     rsp_stall <= ($urandom_range(0, 9) < 8);
         STALL_ALTERNATE: rsp_stall <= ~rsp_stall;
         default:         rsp_stall <= 1'b0;
      endcase
   end

   task automatic idle(input int n);
      @(negedge clock);
      req_valid   <= 1'b0;
      req_rx_byte <= 8'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fn, input logic fs);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_func        <= fn;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 32);
         if ($urandom_range(0, 3) != 0) begin
            idle($urandom_range(1, 6));
         end
      end
   endtask

   task automatic send_frame(input logic [15:0] value, input logic fn, input logic fs_first,
                             input logic [7:0] crc_flip);
      send_byte(value[15:8], fn, fs_first);
      send_byte(value[7:0], 1'($urandom_range(0, 1)), 1'b0);
      send_byte(frame_checksum(value) ^ crc_flip, 1'($urandom_range(0, 1)), 1'b0);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin
      logic [15:0] value;
      logic        fn;
      logic [7:0]  flip;
      bit          paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // temperature and humidity extremes
      send_frame(16'h0000, 1'b0, 1'b1, 8'h00);
      send_frame(16'hFFFC, 1'b0, 1'b1, 8'h00);
      send_frame(16'h0002, 1'b1, 1'b1, 8'h00);
      send_frame(16'hFFFE, 1'b1, 1'b1, 8'h00);
      // bad checksum, bad checksum with wrong kind, wrong kind only
      send_frame(16'h6541, 1'b0, 1'b1, 8'h80);
      send_frame(16'h6543, 1'b0, 1'b1, 8'h01);
      send_frame(16'h6A42, 1'b0, 1'b1, 8'h00);
      // partial frame dropped by a new frame start
      send_byte(8'hA5, 1'b1, 1'b1);
      send_frame(16'h7FFF, 1'b1, 1'b1, 8'h00);
      // frame counted on without the start flag
      send_frame(16'h1234, 1'b0, 1'b0, 8'h00);

      while (bytes_sent < RANDOM_BYTES) begin
         if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
            wait_results_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 85) begin
            value = 16'($urandom);
            fn = 1'($urandom_range(0, 1));
            value[1] = ($urandom_range(0, 9) < 8) ? fn : ~fn;
            flip = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
            send_frame(value, fn, $urandom_range(0, 4) != 0, flip);
         end else begin
            repeat ($urandom_range(1, 2)) begin
               send_byte(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 9) < 3);
            end
         end
      end

      wait_results_drained();
      repeat (END_WAIT) @(negedge clock);
      $display("Run covered %0d bytes in %0d complete frames under bursty input and stalls",
               bytes_seen, frames_ok + frames_crc_err + frames_kind_err);
      $display("Frames converted %0d, checksum errors %0d, kind errors %0d",
               frames_ok, frames_crc_err, frames_kind_err);
      if (fail_count == 0 && pending_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
